@@ rtl/max_subarray_sum_with_bounds_top_defines.svh @@
// Assertion macros for the maximum subarray sum block.
// Included by the top level; depends on nothing else.
`ifndef MAX_SUBARRAY_SUM_WITH_BOUNDS_TOP_DEFINES_SVH
`define MAX_SUBARRAY_SUM_WITH_BOUNDS_TOP_DEFINES_SVH

// Checks a property on every rising clock edge once reset has been released.
`define MSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define MSS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/mss_pkg.sv @@
// Shared types and constants for the maximum subarray sum block.
// Used by every RTL module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned SumW       = 31;
  localparam int unsigned PosOutW    = 16;
  localparam int unsigned MaxLenDflt = 65536;

  // One input item as held in the input register.
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_item;
  } in_item_t;

endpackage

`default_nettype wire

@@ rtl/mss_in_stage.sv @@
// Input register of the maximum subarray sum block.
// Depends on mss_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module mss_in_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire mss_pkg::in_item_t     item_i,
  output      logic                  vld_o,
  output      mss_pkg::in_item_t     item_o,
  input  wire logic                  take_i
);

  logic              vld_q, vld_d;
  mss_pkg::in_item_t item_q;
  logic              accept;

  // The register is free when empty or when its item is consumed this cycle.
  assign in_stall_o = vld_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

@@ rtl/mss_scan.sv @@
// Single-pass scan state and result register of the maximum subarray sum block.
// Depends on mss_pkg for widths and the item type.
`timescale 1ns / 1ps
`default_nettype none

module mss_scan #(
  parameter int unsigned MAX_LENGTH = mss_pkg::MaxLenDflt
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          vld_i,
  input  wire mss_pkg::in_item_t             item_i,
  output      logic                          take_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [mss_pkg::SumW-1:0]      best_sum_o,
  output      logic [mss_pkg::PosOutW-1:0]   first_position_o,
  output      logic [mss_pkg::PosOutW-1:0]   final_position_o
);

  localparam int unsigned PosW = $clog2(MAX_LENGTH);
  localparam int unsigned SumW = mss_pkg::SumW;
  localparam int unsigned ExtW = PosW + mss_pkg::PosOutW;

  logic [PosW-1:0] pos_q, pos_d, pos_next;
  logic [SumW-1:0] suffix_q, suffix_d;
  logic [PosW-1:0] sstart_q, sstart_d;
  logic [SumW-1:0] best_q, best_d;
  logic [PosW-1:0] bstart_q, bstart_d;
  logic [PosW-1:0] bend_q, bend_d;

  logic signed [SumW+1:0] sum_t;
  logic [SumW-1:0]        sum_sat;
  logic                   sum_neg;
  logic                   better;

  logic [SumW-1:0] upd_best;
  logic [PosW-1:0] upd_bstart, upd_bend;
  logic [ExtW-1:0] ext_first, ext_final;

  logic                        out_valid_q, out_valid_d;
  logic [SumW-1:0]             best_sum_q;
  logic [mss_pkg::PosOutW-1:0] first_q, final_q;

  // A last item needs the result register; other items only update the state.
  assign take_o = vld_i && (!item_i.last_item || !out_valid_q || !out_stall_i);

  assign pos_next = (pos_q == PosW'(MAX_LENGTH - 1)) ? pos_q : pos_q + 1'b1;

  assign sum_t   = $signed({2'b00, suffix_q})
                 + $signed({{(SumW + 2 - mss_pkg::SampleW){item_i.sample[mss_pkg::SampleW-1]}},
                            item_i.sample});
  assign sum_neg = sum_t[SumW+1];
  // A non-negative sum that reaches bit 31 is saturated at the top of range.
  assign sum_sat = sum_t[SumW] ? {SumW{1'b1}} : sum_t[SumW-1:0];
  assign better  = !sum_neg && (sum_sat > best_q);

  assign upd_best   = better ? sum_sat  : best_q;
  assign upd_bstart = better ? sstart_q : bstart_q;
  assign upd_bend   = better ? pos_q    : bend_q;

  always_comb begin
    pos_d    = pos_q;
    suffix_d = suffix_q;
    sstart_d = sstart_q;
    best_d   = best_q;
    bstart_d = bstart_q;
    bend_d   = bend_q;
    if (take_o) begin
      if (item_i.last_item) begin
        pos_d    = '0;
        suffix_d = '0;
        sstart_d = '0;
        best_d   = '0;
        bstart_d = '0;
        bend_d   = '0;
      end else begin
        pos_d    = pos_next;
        suffix_d = sum_neg ? '0 : sum_sat;
        sstart_d = sum_neg ? pos_next : sstart_q;
        best_d   = upd_best;
        bstart_d = upd_bstart;
        bend_d   = upd_bend;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      suffix_q <= '0;
      sstart_q <= '0;
      best_q   <= '0;
      bstart_q <= '0;
      bend_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      suffix_q <= suffix_d;
      sstart_q <= sstart_d;
      best_q   <= best_d;
      bstart_q <= bstart_d;
      bend_q   <= bend_d;
    end
  end

  // Reported positions keep only their low 16 bits.
  assign ext_first = {{mss_pkg::PosOutW{1'b0}}, upd_bstart};
  assign ext_final = {{mss_pkg::PosOutW{1'b0}}, upd_bend};

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o && item_i.last_item) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && item_i.last_item) begin
      best_sum_q <= upd_best;
      first_q    <= ext_first[mss_pkg::PosOutW-1:0];
      final_q    <= ext_final[mss_pkg::PosOutW-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign best_sum_o       = best_sum_q;
  assign first_position_o = first_q;
  assign final_position_o = final_q;

endmodule

`default_nettype wire

@@ rtl/max_subarray_sum_with_bounds_top.sv @@
// The result register is loaded when the scan takes the last sample from the input register.
// Throughput: one sample per cycle while no last sample waits for the result register;
// the suffix and best-sum update is one add, one compare and one register load.
// The input register keeps taking samples while a finished result waits, until a
// further last sample has to wait for the result register to be freed.
// Reset is asynchronous, active low, and clears all scan state and valid flags.
`timescale 1ns / 1ps
`default_nettype none
`include "max_subarray_sum_with_bounds_top_defines.svh"

module max_subarray_sum_with_bounds_top #(
  parameter int unsigned MAX_LENGTH = mss_pkg::MaxLenDflt
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic signed [mss_pkg::SampleW-1:0]  sample_i,
  input  wire logic                                last_item_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic [mss_pkg::SumW-1:0]            best_sum_o,
  output      logic [mss_pkg::PosOutW-1:0]         first_position_o,
  output      logic [mss_pkg::PosOutW-1:0]         final_position_o
);

  mss_pkg::in_item_t in_item, stage_item;
  logic              stage_vld;
  logic              take;

  assign in_item.sample    = sample_i;
  assign in_item.last_item = last_item_i;

  mss_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .vld_o      (stage_vld),
    .item_o     (stage_item),
    .take_i     (take)
  );

  mss_scan #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_scan (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .vld_i            (stage_vld),
    .item_i           (stage_item),
    .take_o           (take),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .best_sum_o       (best_sum_o),
    .first_position_o (first_position_o),
    .final_position_o (final_position_o)
  );

  `MSS_ASSERT_NEVER(a_stall_needs_item, clk_i, rst_ni, in_stall_o && !stage_vld, "stall with empty input register")
  `MSS_ASSERT(a_last_gives_result, clk_i, rst_ni, take && stage_item.last_item |=> out_valid_o, "last sample gave no result")
  `MSS_ASSERT(a_no_spurious_result, clk_i, rst_ni, !(take && stage_item.last_item) |=> !$rose(out_valid_o), "result without a last sample")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the maximum subarray sum block (max_subarray_sum_with_bounds_top).
// Predicts each reported range with its own scan model and depends on rtl/mss_pkg.sv and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ScanLen  = mss_pkg::MaxLenDflt;
  localparam longint      SumLimit = 64'sd2147483647;

  typedef struct {
    logic [mss_pkg::SumW-1:0]    total;
    logic [mss_pkg::PosOutW-1:0] start_idx;
    logic [mss_pkg::PosOutW-1:0] end_idx;
  } range_t;

  logic                                clk_i       = 1'b0;
  logic                                rst_ni      = 1'b0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_stall_o;
  logic signed [mss_pkg::SampleW-1:0]  sample_i    = '0;
  logic                                last_item_i = 1'b0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic [mss_pkg::SumW-1:0]            best_sum_o;
  logic [mss_pkg::PosOutW-1:0]         first_position_o;
  logic [mss_pkg::PosOutW-1:0]         final_position_o;

  // Scan state of the predictor.
  int unsigned scan_pos;
  longint      suffix_sum;
  int unsigned suffix_first;
  longint      best_total;
  int unsigned best_first;
  int unsigned best_last;

  range_t expected_ranges[$];
  int     error_count    = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;

  max_subarray_sum_with_bounds_top #(
    .MAX_LENGTH(ScanLen)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .last_item_i     (last_item_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .best_sum_o      (best_sum_o),
    .first_position_o(first_position_o),
    .final_position_o(final_position_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic int unsigned step_pos(input int unsigned p);
    return (p + 1 >= ScanLen) ? p : p + 1;
  endfunction

  function automatic void clear_scan();
    scan_pos     = 0;
    suffix_sum   = 0;
    suffix_first = 0;
    best_total   = 0;
    best_first   = 0;
    best_last    = 0;
  endfunction

  // Kadane step: the suffix is dropped when it goes negative, and a new best
  // needs a strictly greater sum so that the earliest range wins a tie.
  function automatic void scan_sample(input logic signed [mss_pkg::SampleW-1:0] value,
                                      input logic is_last);
    longint sum;
    range_t found;
    sum = suffix_sum + longint'(value);
    if (sum < 0) begin
      suffix_sum   = 0;
      suffix_first = step_pos(scan_pos);
    end else begin
      if (sum > SumLimit) sum = SumLimit;
      suffix_sum = sum;
      if (sum > best_total) begin
        best_total = sum;
        best_first = suffix_first;
        best_last  = scan_pos;
      end
    end
    if (is_last) begin
      found.total     = best_total[mss_pkg::SumW-1:0];
      found.start_idx = best_first[mss_pkg::PosOutW-1:0];
      found.end_idx   = best_last[mss_pkg::PosOutW-1:0];
      expected_ranges.push_back(found);
      clear_scan();
    end else begin
      scan_pos = step_pos(scan_pos);
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Sends one sample. Stall is looked at on the falling edge, where every
  // signal is settled, and decides the transfer at the following rising edge.
  task automatic send_sample(input logic signed [mss_pkg::SampleW-1:0] value,
                             input logic is_last);
    bit taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_i    <= value;
    last_item_i <= is_last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    scan_sample(value, is_last);
  endtask

  always @(negedge clk_i) begin : result_check
    range_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_ranges.size() == 0) begin
        report_mismatch("unexpected result, best_sum", best_sum_o, -1);
      end else begin
        want = expected_ranges.pop_front();
        if (best_sum_o !== want.total)
          report_mismatch("best_sum", best_sum_o, want.total);
        if (first_position_o !== want.start_idx)
          report_mismatch("first_position", first_position_o, want.start_idx);
        if (final_position_o !== want.end_idx)
          report_mismatch("final_position", final_position_o, want.end_idx);
      end
    end
  end

  function automatic logic signed [mss_pkg::SampleW-1:0] random_sample();
    int pick;
    case ($urandom_range(0, 4))
      0: pick = int'($urandom_range(0, 20)) - 10;
      1: pick = int'($urandom_range(0, 2000)) - 1000;
      2: pick = $urandom_range(0, 1) ? 32767 : -32768;
      default: pick = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return pick[mss_pkg::SampleW-1:0];
  endfunction

  task automatic test_single_item();
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd0, 1'b1);
  endtask

  task automatic test_no_positive_sum();
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd7, 1'b1);
  endtask

  // A suffix that falls to exactly zero keeps its start; equal sums never
  // replace the earlier best.
  task automatic test_ties();
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd3, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd4, 1'b0);
    send_sample(-16'sd4, 1'b0);
    send_sample(16'sd4, 1'b1);
  endtask

  task automatic test_bit_patterns();
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b0);
    send_sample(16'sh5555, 1'b1);
  endtask

  // Mostly short sequences so that results come often, with a few long ones.
  task automatic test_random_sequences(input int item_count);
    int sent;
    int seq_len;
    sent = 0;
    while (sent < item_count) begin
      seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
      for (int k = 0; k < seq_len; k++) begin
        send_sample(random_sample(), k == seq_len - 1);
      end
      sent += seq_len;
    end
  endtask

  initial begin
    clear_scan();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 14;
    recv_stall_pct = 60;
    test_single_item();
    test_no_positive_sum();
    test_ties();
    test_bit_patterns();
    test_random_sequences(620);

    send_idle_pct  = 60;
    recv_stall_pct = 14;
    test_random_sequences(620);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_sequences(610);

    in_valid_i <= 1'b0;
    while (expected_ranges.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
